FILE: hdl/lfsp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lfsp_pkg;

   // Sizing
   localparam int MAX_LEDS = 4096;
   localparam int LED_W    = 13;
   localparam int POS_W    = 14;
   localparam int CNT_W    = 16;

   // Parser states
   localparam logic [3:0] ST_HEAD_A     = 4'd0;
   localparam logic [3:0] ST_HEAD_2     = 4'd1;
   localparam logic [3:0] ST_HEAD_3     = 4'd2;
   localparam logic [3:0] ST_COUNT_HI   = 4'd3;
   localparam logic [3:0] ST_COUNT_LO   = 4'd4;
   localparam logic [3:0] ST_HEAD_CHECK = 4'd5;
   localparam logic [3:0] ST_PAYLOAD    = 4'd6;
   localparam logic [3:0] ST_CALIB      = 4'd7;
   localparam logic [3:0] ST_SUM1       = 4'd8;
   localparam logic [3:0] ST_SUM2       = 4'd9;
   localparam logic [3:0] ST_SUMX       = 4'd10;

   // Event codes
   localparam logic [1:0] EV_NONE      = 2'd0;
   localparam logic [1:0] EV_FRAME     = 2'd1;
   localparam logic [1:0] EV_HANDSHAKE = 2'd2;
   localparam logic [1:0] EV_SLEEP     = 2'd3;

   // Error codes
   localparam logic [2:0] ER_NONE     = 3'd0;
   localparam logic [2:0] ER_HEADER   = 3'd1;
   localparam logic [2:0] ER_VERSION3 = 3'd2;
   localparam logic [2:0] ER_COUNT    = 3'd3;
   localparam logic [2:0] ER_CHECKSUM = 3'd4;

   // Framing bytes
   localparam logic [7:0] CH_UPPER_A    = 8'h41;
   localparam logic [7:0] CH_LOWER_W    = 8'h77;
   localparam logic [7:0] CH_UPPER_W    = 8'h57;
   localparam logic [7:0] CH_LOWER_A    = 8'h61;
   localparam logic [7:0] HDR_XOR       = 8'h55;
   localparam logic [CNT_W-1:0] SPECIAL_COUNT = 16'h2AA2;
   localparam logic [7:0] CHK_HANDSHAKE = 8'h15;
   localparam logic [7:0] CHK_SLEEP     = 8'h35;
   localparam logic [7:0] SUMX_ESCAPED  = 8'h41;
   localparam logic [7:0] SUMX_SUBST    = 8'hAA;
   localparam logic [2:0] CALIB_BYTES   = 3'd4;
   localparam logic [9:0] MOD_SUM       = 10'd255;

endpackage

`default_nettype wire

FILE: hdl/led_frame_stream_parser_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Ports                          Direction  Transfer when
// req       req_valid/req_stall/req_data_* in         req_valid && !req_stall
// rsp       rsp_valid/rsp_stall/rsp_*      out        rsp_valid && !rsp_stall
// csr       csr_write_enable/csr_write_data in        csr_write_enable
//
// One byte per cycle while rsp_stall is low; each byte passes through the input
// register, then the parse step into the result register.
// The parse step is one pass of compare, add and mod-255 fold logic.
// reset is synchronous, active high; led_count returns to 1, parser to idle.
// A stalled result holds; the input register still takes one more byte.
module led_frame_stream_parser_top (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire logic [7:0]                 req_data_byte,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic [1:0]                      rsp_event_code,
   output logic [2:0]                      rsp_error_code,
   output logic                            rsp_pixel_valid,
   output logic [lfsp_pkg::POS_W-1:0]      rsp_pixel_index,
   output logic [7:0]                      rsp_pixel_byte,
   output logic                            rsp_frame_is_version2,
   input  wire logic                       csr_write_enable,
   input  wire logic [lfsp_pkg::LED_W-1:0] csr_write_data
);

   localparam int POS_W = lfsp_pkg::POS_W;
   localparam int LED_W = lfsp_pkg::LED_W;
   localparam int CNT_W = lfsp_pkg::CNT_W;

   // Configuration
   logic [LED_W-1:0] led_count_ff;

   // Input register
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;

   // Frame state
   logic [3:0]       state_ff,  state_in;
   logic             v2_ff,     v2_in;
   logic [CNT_W-1:0] count_ff,  count_in;
   logic [7:0]       check_ff,  check_in;
   logic [POS_W-1:0] ppos_ff,   ppos_in;
   logic [POS_W-1:0] len_ff,    len_in;
   logic [2:0]       calib_ff,  calib_in;
   logic [7:0]       s1_ff,     s1_in;
   logic [7:0]       s2_ff,     s2_in;
   logic [7:0]       sx_ff,     sx_in;
   logic [POS_W-1:0] cpos_ff,   cpos_in;

   // Result register
   logic                 rsp_valid_ff;
   logic [1:0]           ev_ff;
   logic [2:0]           er_ff;
   logic                 pv_ff;
   logic [POS_W-1:0]     pidx_ff;
   logic [7:0]           pbyte_ff;
   logic                 v2o_ff;

   logic work;
   logic in_free;

   // Step outputs
   logic [1:0]       ev;
   logic [2:0]       er;
   logic             pv;
   logic [POS_W-1:0] pidx;
   logic [7:0]       pbyte;
   logic             v2_out;
   logic             do_clear;

   // Checksum datapath
   logic [9:0]       s1_sum, s1_red, s2_sum, s2_red, sx_sum, sx_fold;
   logic [7:0]       s1_new, s2_new, sx_new, sx_expect;
   logic [CNT_W:0]   count_plus1;
   logic [POS_W:0]   ppos_next;
   logic [POS_W+1:0] len_calc;
   logic             count_ok;
   logic [7:0]       b;

   assign b    = in_byte_ff;
   assign work = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign in_free   = !in_valid_ff || work;
   assign req_stall = !in_free;

   // Mod-255 sums; 256 folds to 1 for the position high byte
   always_comb begin
      s1_sum  = {2'b00, s1_ff} + {2'b00, b};
      s1_red  = (s1_sum >= lfsp_pkg::MOD_SUM) ? s1_sum - lfsp_pkg::MOD_SUM : s1_sum;
      s1_new  = s1_red[7:0];
      s2_sum  = {2'b00, s2_ff} + {2'b00, s1_new};
      s2_red  = (s2_sum >= lfsp_pkg::MOD_SUM) ? s2_sum - lfsp_pkg::MOD_SUM : s2_sum;
      s2_new  = s2_red[7:0];
      sx_sum  = {2'b00, sx_ff} + {{(10-(POS_W-8)){1'b0}}, cpos_ff[POS_W-1:8]}
              + {2'b00, b ^ cpos_ff[7:0]};
      sx_fold = {8'd0, sx_sum[9:8]} + {2'b00, sx_sum[7:0]};
      sx_new  = (sx_fold >= lfsp_pkg::MOD_SUM) ? 8'(sx_fold - lfsp_pkg::MOD_SUM)
                                               : sx_fold[7:0];
      sx_expect = (sx_ff != lfsp_pkg::SUMX_ESCAPED) ? sx_ff : lfsp_pkg::SUMX_SUBST;
   end

   // Header count check and payload length
   always_comb begin
      count_plus1 = {1'b0, count_ff} + {{CNT_W{1'b0}}, 1'b1};
      count_ok    = (count_plus1 == {{(CNT_W+1-LED_W){1'b0}}, led_count_ff})
                 && (led_count_ff != '0)
                 && ({{(32-LED_W){1'b0}}, led_count_ff} <= 32'(lfsp_pkg::MAX_LEDS));
      len_calc    = {2'b00, led_count_ff, 1'b0} + {3'b000, led_count_ff};
      ppos_next   = {1'b0, ppos_ff} + {{POS_W{1'b0}}, 1'b1};
   end

   // Parse one byte
   always_comb begin
      state_in = state_ff;
      v2_in    = v2_ff;
      count_in = count_ff;
      check_in = check_ff;
      ppos_in  = ppos_ff;
      len_in   = len_ff;
      calib_in = calib_ff;
      s1_in    = s1_ff;
      s2_in    = s2_ff;
      sx_in    = sx_ff;
      cpos_in  = cpos_ff;
      ev       = lfsp_pkg::EV_NONE;
      er       = lfsp_pkg::ER_NONE;
      pv       = 1'b0;
      pidx     = '0;
      pbyte    = 8'd0;
      do_clear = 1'b0;

      case (state_ff)
         lfsp_pkg::ST_HEAD_A: begin
            if (b == lfsp_pkg::CH_UPPER_A) state_in = lfsp_pkg::ST_HEAD_2;
         end
         lfsp_pkg::ST_HEAD_2: begin
            if (b == lfsp_pkg::CH_LOWER_W) begin
               state_in = lfsp_pkg::ST_HEAD_3;
            end else begin
               er = (b == lfsp_pkg::CH_UPPER_W) ? lfsp_pkg::ER_VERSION3
                                                : lfsp_pkg::ER_HEADER;
               do_clear = 1'b1;
            end
         end
         lfsp_pkg::ST_HEAD_3: begin
            if (b == lfsp_pkg::CH_LOWER_A) begin
               v2_in    = 1'b0;
               state_in = lfsp_pkg::ST_COUNT_HI;
            end else if (b == lfsp_pkg::CH_UPPER_A) begin
               v2_in    = 1'b1;
               state_in = lfsp_pkg::ST_COUNT_HI;
            end else begin
               er       = lfsp_pkg::ER_HEADER;
               do_clear = 1'b1;
            end
         end
         lfsp_pkg::ST_COUNT_HI: begin
            count_in = {b, 8'd0};
            check_in = b;
            s1_in    = 8'd0;
            s2_in    = 8'd0;
            sx_in    = 8'd0;
            cpos_in  = '0;
            ppos_in  = '0;
            state_in = lfsp_pkg::ST_COUNT_LO;
         end
         lfsp_pkg::ST_COUNT_LO: begin
            count_in = count_ff + {8'd0, b};
            check_in = check_ff ^ b ^ lfsp_pkg::HDR_XOR;
            state_in = lfsp_pkg::ST_HEAD_CHECK;
         end
         lfsp_pkg::ST_HEAD_CHECK: begin
            if (check_ff != b) begin
               if (count_ff == lfsp_pkg::SPECIAL_COUNT && b == lfsp_pkg::CHK_HANDSHAKE) begin
                  ev       = lfsp_pkg::EV_HANDSHAKE;
                  do_clear = 1'b1;
               end else if (count_ff == lfsp_pkg::SPECIAL_COUNT &&
                            b == lfsp_pkg::CHK_SLEEP) begin
                  ev       = lfsp_pkg::EV_SLEEP;
                  do_clear = 1'b1;
               end else begin
                  er       = lfsp_pkg::ER_HEADER;
                  do_clear = 1'b1;
               end
            end else if (!count_ok) begin
               er       = lfsp_pkg::ER_COUNT;
               do_clear = 1'b1;
            end else begin
               len_in   = len_calc[POS_W-1:0];
               state_in = lfsp_pkg::ST_PAYLOAD;
            end
         end
         lfsp_pkg::ST_PAYLOAD: begin
            pv      = 1'b1;
            pidx    = ppos_ff;
            pbyte   = b;
            s1_in   = s1_new;
            s2_in   = s2_new;
            sx_in   = sx_new;
            cpos_in = cpos_ff + {{(POS_W-1){1'b0}}, 1'b1};
            ppos_in = ppos_next[POS_W-1:0];
            if (ppos_next >= {1'b0, len_ff}) begin
               if (v2_ff) begin
                  calib_in = lfsp_pkg::CALIB_BYTES;
                  state_in = lfsp_pkg::ST_CALIB;
               end else begin
                  state_in = lfsp_pkg::ST_SUM1;
               end
            end
         end
         lfsp_pkg::ST_CALIB: begin
            s1_in    = s1_new;
            s2_in    = s2_new;
            sx_in    = sx_new;
            cpos_in  = cpos_ff + {{(POS_W-1){1'b0}}, 1'b1};
            calib_in = calib_ff - 3'd1;
            if (calib_ff == 3'd1) state_in = lfsp_pkg::ST_SUM1;
         end
         lfsp_pkg::ST_SUM1: begin
            if (b != s1_ff) begin
               er       = lfsp_pkg::ER_CHECKSUM;
               do_clear = 1'b1;
            end else begin
               state_in = lfsp_pkg::ST_SUM2;
            end
         end
         lfsp_pkg::ST_SUM2: begin
            if (b != s2_ff) begin
               er       = lfsp_pkg::ER_CHECKSUM;
               do_clear = 1'b1;
            end else begin
               state_in = lfsp_pkg::ST_SUMX;
            end
         end
         lfsp_pkg::ST_SUMX: begin
            if (b != sx_expect) begin
               er = lfsp_pkg::ER_CHECKSUM;
            end else begin
               ev = lfsp_pkg::EV_FRAME;
            end
            do_clear = 1'b1;
         end
         default: begin
            do_clear = 1'b1;
         end
      endcase

      // Drop frame state; an offending 'A' restarts the header on errors
      if (do_clear) begin
         v2_in    = 1'b0;
         count_in = '0;
         check_in = 8'd0;
         ppos_in  = '0;
         len_in   = '0;
         calib_in = 3'd0;
         s1_in    = 8'd0;
         s2_in    = 8'd0;
         sx_in    = 8'd0;
         cpos_in  = '0;
         if (er != lfsp_pkg::ER_NONE && b == lfsp_pkg::CH_UPPER_A) begin
            state_in = lfsp_pkg::ST_HEAD_2;
         end else begin
            state_in = lfsp_pkg::ST_HEAD_A;
         end
      end

      v2_out = (ev == lfsp_pkg::EV_FRAME) ? v2_ff : v2_in;
   end

   // Hold configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         led_count_ff <= {{(LED_W-1){1'b0}}, 1'b1};
      end else if (csr_write_enable) begin
         led_count_ff <= csr_write_data;
      end
   end

   // Capture input transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (in_free) begin
         in_valid_ff <= req_valid;
      end
      if (in_free && req_valid) in_byte_ff <= req_data_byte;
   end

   // Advance frame state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lfsp_pkg::ST_HEAD_A;
         v2_ff    <= 1'b0;
         count_ff <= '0;
         check_ff <= 8'd0;
         ppos_ff  <= '0;
         len_ff   <= '0;
         calib_ff <= 3'd0;
         s1_ff    <= 8'd0;
         s2_ff    <= 8'd0;
         sx_ff    <= 8'd0;
         cpos_ff  <= '0;
      end else if (work) begin
         state_ff <= state_in;
         v2_ff    <= v2_in;
         count_ff <= count_in;
         check_ff <= check_in;
         ppos_ff  <= ppos_in;
         len_ff   <= len_in;
         calib_ff <= calib_in;
         s1_ff    <= s1_in;
         s2_ff    <= s2_in;
         sx_ff    <= sx_in;
         cpos_ff  <= cpos_in;
      end
   end

   // Load result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (work) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (work) begin
         ev_ff    <= ev;
         er_ff    <= er;
         pv_ff    <= pv;
         pidx_ff  <= pidx;
         pbyte_ff <= pbyte;
         v2o_ff   <= v2_out;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_event_code        = ev_ff;
   assign rsp_error_code        = er_ff;
   assign rsp_pixel_valid       = pv_ff;
   assign rsp_pixel_index       = pidx_ff;
   assign rsp_pixel_byte        = pbyte_ff;
   assign rsp_frame_is_version2 = v2o_ff;

   // Parser never leaves the defined state range
   a_state_range: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> state_ff <= lfsp_pkg::ST_SUMX)
      else $error("parser state out of range");

   // Payload position stays below the latched frame length
   a_payload_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == lfsp_pkg::ST_PAYLOAD |-> ppos_ff < len_ff)
      else $error("payload position past frame length");

   // Calibration countdown is live while in calibration
   a_calib_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == lfsp_pkg::ST_CALIB |-> calib_ff != 3'd0 && calib_ff <= lfsp_pkg::CALIB_BYTES)
      else $error("calibration count invalid");

   // A payload transfer carries no event and no error
   a_pixel_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_pixel_valid |->
         rsp_event_code == lfsp_pkg::EV_NONE && rsp_error_code == lfsp_pkg::ER_NONE)
      else $error("payload byte flagged with event or error");

endmodule

`default_nettype wire
